### hw/rtl/rse2d_pkg.sv
// Shared widths, codes and types of the rotation-safe 2D extent block.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package rse2d_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int DIM_W      = 11;
  localparam int POS_W      = 10;
  localparam int DEV_W      = 11;
  localparam int SQ_W       = 22;
  localparam int ROOT_W     = 11;
  localparam int TRIM_W     = 10;
  localparam int DEST_W     = 12;
  localparam int PIX_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS      = 2'd0,
    CFG_COLS      = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DEV_W-1:0] max_row_dev;
    logic [DEV_W-1:0] max_col_dev;
    logic [SQ_W-1:0]  max_sq;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } summary_t;

  typedef struct packed {
    logic              push;
  } queue_ctl_t;

  typedef struct packed {
    logic [TRIM_W-1:0] trim;
    logic [DIM_W-1:0]  crop;
    logic [DEST_W-1:0] dest;
    logic [DIM_W-1:0]  paste;
  } axis_t;

endpackage
`default_nettype wire

### hw/rtl/rse2d_front.sv
// Front part: accepts pixels, tracks position and content extent per frame.
// Pushes one frame summary per last pixel. Depends on rse2d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rse2d_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [rse2d_pkg::PIX_W-1:0] pixel_value,
  input  wire logic                              last_pixel,
  input  wire logic [rse2d_pkg::DIM_W-1:0]       rows_eff,
  input  wire logic [rse2d_pkg::DIM_W-1:0]       cols_eff,
  input  wire logic signed [rse2d_pkg::PIX_W-1:0] threshold,
  input  wire logic [rse2d_pkg::QCNT_W-1:0]      q_count,
  output rse2d_pkg::queue_ctl_t                  q_ctl,
  output rse2d_pkg::summary_t                    q_data
);
  import rse2d_pkg::*;

  function automatic logic [DEV_W-1:0] doubled_dev(input logic [POS_W-1:0] pos,
                                                   input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] p;
    logic [DIM_W-1:0] a;
    logic [DIM_W-1:0] b;
    b = dim - DIM_W'(1);
    p = ({1'b0, pos} >= dim) ? b : {1'b0, pos};
    a = {p[DIM_W-2:0], 1'b0};
    return (a >= b) ? DEV_W'(a - b) : DEV_W'(b - a);
  endfunction

  logic                 accept;
  logic [POS_W-1:0]     row_r, col_r;
  logic [DIM_W-1:0]     col_inc, row_inc;

  logic                 s1_valid_r, s1_hit_r, s1_last_r;
  logic [DEV_W-1:0]     s1_dr_r, s1_dc_r;
  logic [DIM_W-1:0]     s1_rows_r, s1_cols_r;

  logic                 s2_valid_r, s2_hit_r, s2_last_r;
  logic [DEV_W-1:0]     s2_dr_r, s2_dc_r;
  logic [SQ_W-2:0]      s2_sqr_r, s2_sqc_r;
  logic [DIM_W-1:0]     s2_rows_r, s2_cols_r;

  logic [DEV_W:0]       dr1, dc1;
  logic [2*DEV_W+1:0]   prod_r, prod_c;

  logic [DEV_W-1:0]     max_dr_r, max_dc_r, max_dr_nxt, max_dc_nxt;
  logic [SQ_W-1:0]      max_sq_r, max_sq_nxt, sq_sum;
  logic [QCNT_W+1:0]    credit;

  assign credit = {2'b00, q_count} + (QCNT_W+2)'(s1_last_r) + (QCNT_W+2)'(s2_last_r);
  assign full   = (credit >= (QCNT_W+2)'(QDEPTH));
  assign accept = push && !full;

  assign col_inc = {1'b0, col_r} + DIM_W'(1);
  assign row_inc = {1'b0, row_r} + DIM_W'(1);

  assign dr1    = {1'b0, s1_dr_r} + (DEV_W+1)'(1);
  assign dc1    = {1'b0, s1_dc_r} + (DEV_W+1)'(1);
  assign prod_r = dr1 * dr1;
  assign prod_c = dc1 * dc1;

  assign sq_sum = {1'b0, s2_sqr_r} + {1'b0, s2_sqc_r};

  always_comb begin
    max_dr_nxt = max_dr_r;
    max_dc_nxt = max_dc_r;
    max_sq_nxt = max_sq_r;
    if (s2_hit_r) begin
      if (s2_dr_r > max_dr_r) max_dr_nxt = s2_dr_r;
      if (s2_dc_r > max_dc_r) max_dc_nxt = s2_dc_r;
      if (sq_sum > max_sq_r) max_sq_nxt = sq_sum;
    end
  end

  assign q_ctl.push         = s2_valid_r && s2_last_r;
  assign q_data.max_row_dev = max_dr_nxt;
  assign q_data.max_col_dev = max_dc_nxt;
  assign q_data.max_sq      = max_sq_nxt;
  assign q_data.rows        = s2_rows_r;
  assign q_data.cols        = s2_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
      max_dr_r   <= '0;
      max_dc_r   <= '0;
      max_sq_r   <= '0;
    end else begin
      s1_valid_r <= accept;
      s1_last_r  <= accept && last_pixel;
      s2_valid_r <= s1_valid_r;
      s2_last_r  <= s1_valid_r && s1_last_r;
      if (accept) begin
        if (last_pixel) begin
          row_r <= '0;
          col_r <= '0;
        end else if (col_inc >= cols_eff) begin
          col_r <= '0;
          row_r <= (row_inc >= rows_eff) ? '0 : row_inc[POS_W-1:0];
        end else begin
          col_r <= col_inc[POS_W-1:0];
        end
      end
      if (s2_valid_r) begin
        if (s2_last_r) begin
          max_dr_r <= '0;
          max_dc_r <= '0;
          max_sq_r <= '0;
        end else begin
          max_dr_r <= max_dr_nxt;
          max_dc_r <= max_dc_nxt;
          max_sq_r <= max_sq_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_hit_r  <= (pixel_value > threshold);
    s1_dr_r   <= doubled_dev(row_r, rows_eff);
    s1_dc_r   <= doubled_dev(col_r, cols_eff);
    s1_rows_r <= rows_eff;
    s1_cols_r <= cols_eff;
    s2_hit_r  <= s1_valid_r && s1_hit_r;
    s2_dr_r   <= s1_dr_r;
    s2_dc_r   <= s1_dc_r;
    s2_sqr_r  <= prod_r[SQ_W-2:0];
    s2_sqc_r  <= prod_c[SQ_W-2:0];
    s2_rows_r <= s1_rows_r;
    s2_cols_r <= s1_cols_r;
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_last_r) |=> (max_sq_r == '0 && max_dr_r == '0 && max_dc_r == '0))
    else $error("extent not cleared after frame end");

endmodule
`default_nettype wire

### hw/rtl/rse2d_queue.sv
// Short queue of frame summaries between the front and back parts.
// Depends on rse2d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rse2d_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire rse2d_pkg::summary_t           push_data,
  input  wire logic                          pop,
  output logic                               not_empty,
  output rse2d_pkg::summary_t                pop_data,
  output logic [rse2d_pkg::QCNT_W-1:0]       count
);
  import rse2d_pkg::*;

  summary_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != QCNT_W'(QDEPTH) || pop))
    else $error("summary queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("summary queue underflow");

endmodule
`default_nettype wire

### hw/rtl/rse2d_back.sv
// Back part: ceiling square root of the corner distance, then crop and destination
// geometry per axis, or zeros and an error flag for an empty frame, into the result register. Depends on rse2d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rse2d_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire rse2d_pkg::summary_t          q_data,
  output logic                              q_pop,
  input  wire logic                         pop,
  output logic                              empty,
  output logic                              empty_error,
  output logic [rse2d_pkg::TRIM_W-1:0]      crop_row_offset,
  output logic [rse2d_pkg::TRIM_W-1:0]      crop_col_offset,
  output logic [rse2d_pkg::DIM_W-1:0]       crop_rows,
  output logic [rse2d_pkg::DIM_W-1:0]       crop_cols,
  output logic [rse2d_pkg::DEST_W-1:0]      dest_rows,
  output logic [rse2d_pkg::DEST_W-1:0]      dest_cols,
  output logic [rse2d_pkg::DIM_W-1:0]       paste_row_offset,
  output logic [rse2d_pkg::DIM_W-1:0]       paste_col_offset
);
  import rse2d_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    ROOT,
    FINISH
  } state_t;

  localparam logic [SQ_W-1:0] BIT_INIT = SQ_W'(1) << (SQ_W - 2);

  function automatic axis_t axis_calc(input logic [DIM_W-1:0]  dim,
                                     input logic [DEV_W-1:0]  dev,
                                     input logic [ROOT_W-1:0] diag);
    logic [DIM_W-1:0]  dm1;
    logic [DIM_W-1:0]  d;
    logic [DIM_W-1:0]  spare;
    logic [DEST_W-1:0] s;
    logic [DEST_W-1:0] c_ext;
    logic [DEST_W-1:0] gap;
    axis_t             a;
    dm1     = dim - DIM_W'(1);
    d       = (DIM_W'(dev) > dm1) ? dm1 : DIM_W'(dev);
    spare   = dm1 - d;
    a.trim  = spare[DIM_W-1:1];
    a.crop  = dim - {a.trim, 1'b0};
    s       = {1'b0, diag} + DEST_W'(diag[0] ^ dim[0]);
    c_ext   = {1'b0, a.crop};
    if (s < c_ext) s = c_ext;
    gap     = s - c_ext;
    a.dest  = s;
    a.paste = gap[DEST_W-1:1];
    return a;
  endfunction

  state_t            state_r;
  summary_t          job_r;
  logic [SQ_W-1:0]   n_r, r_r, bit_r;
  logic [SQ_W:0]     trial;
  logic              ge;
  logic [SQ_W-1:0]   n_step, r_step;
  logic [ROOT_W-1:0] diag;
  axis_t             ax_row, ax_col;
  logic              out_valid_r;
  logic              fin_fire;
  logic [SQ_W-1:0]   diag_sq, below_sq;

  assign trial  = {1'b0, r_r} + {1'b0, bit_r};
  assign ge     = ({1'b0, n_r} >= trial);
  assign n_step = ge ? (n_r - trial[SQ_W-1:0]) : n_r;
  assign r_step = ge ? ((r_r >> 1) + bit_r) : (r_r >> 1);

  assign diag   = r_r[ROOT_W-1:0] + ROOT_W'(n_r != '0);
  assign ax_row = axis_calc(job_r.rows, job_r.max_row_dev, diag);
  assign ax_col = axis_calc(job_r.cols, job_r.max_col_dev, diag);

  assign q_pop    = (state_r == IDLE) && q_valid;
  assign empty    = !out_valid_r;
  assign fin_fire = (state_r == FINISH) && (!out_valid_r || pop);

  assign diag_sq  = SQ_W'(diag) * SQ_W'(diag);
  assign below_sq = SQ_W'(diag - ROOT_W'(1)) * SQ_W'(diag - ROOT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_fire) out_valid_r <= 1'b1;
      else if (pop && out_valid_r) out_valid_r <= 1'b0;
      unique case (state_r)
        IDLE: begin
          if (q_valid) begin
            job_r   <= q_data;
            n_r     <= q_data.max_sq;
            r_r     <= '0;
            bit_r   <= BIT_INIT;
            state_r <= ROOT;
          end
        end
        ROOT: begin
          n_r   <= n_step;
          r_r   <= r_step;
          bit_r <= bit_r >> 2;
          if (bit_r[0]) state_r <= FINISH;
        end
        FINISH: begin
          if (fin_fire) begin
            state_r <= IDLE;
            if (job_r.max_sq == '0) begin
              empty_error      <= 1'b1;
              crop_row_offset  <= '0;
              crop_col_offset  <= '0;
              crop_rows        <= '0;
              crop_cols        <= '0;
              dest_rows        <= '0;
              dest_cols        <= '0;
              paste_row_offset <= '0;
              paste_col_offset <= '0;
            end else begin
              empty_error      <= 1'b0;
              crop_row_offset  <= ax_row.trim;
              crop_col_offset  <= ax_col.trim;
              crop_rows        <= ax_row.crop;
              crop_cols        <= ax_col.crop;
              dest_rows        <= ax_row.dest;
              dest_cols        <= ax_col.dest;
              paste_row_offset <= ax_row.paste;
              paste_col_offset <= ax_col.paste;
            end
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  a_root_is_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FINISH && job_r.max_sq != '0) |->
      (diag_sq >= job_r.max_sq && below_sq < job_r.max_sq))
    else $error("square root is not the ceiling root");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pop) |=> (out_valid_r && $stable(dest_rows) && $stable(crop_cols)))
    else $error("waiting result overwritten");

endmodule
`default_nettype wire

### hw/rtl/rotation_safe_extent_2d_unit.sv
// Top level of the rotation-safe 2D extent block: configuration registers,
// front part, summary queue and back part. Depends on rse2d_pkg, rse2d_front,
// rse2d_queue and rse2d_back.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-------------------------
//   pixels   | in_pixel_value, in_last_pixel           | push / full
//   results  | out_empty_error .. out_paste_col_offset | empty / pop
//   config   | cfg_index, cfg_data                     | cfg_we, no wait
//
// One pixel item is taken every cycle while full is low; full rises only when two frame
// summaries are queued or in flight in the front pipeline.
// The back part loads one summary, runs eleven square root steps of two bits each,
// then forms the geometry into the result register before it takes the next summary.
// Reset is synchronous; config registers return to 1, and frame position, extent, queue and control state clear.
// A waiting result blocks the back part; pixels keep flowing into the queue until full rises.
`timescale 1ns / 1ps
`default_nettype none
module rotation_safe_extent_2d_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [rse2d_pkg::PIX_W-1:0]  in_pixel_value,
  input  wire logic                                in_last_pixel,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic                                     out_empty_error,
  output logic [rse2d_pkg::TRIM_W-1:0]             out_crop_row_offset,
  output logic [rse2d_pkg::TRIM_W-1:0]             out_crop_col_offset,
  output logic [rse2d_pkg::DIM_W-1:0]              out_crop_rows,
  output logic [rse2d_pkg::DIM_W-1:0]              out_crop_cols,
  output logic [rse2d_pkg::DEST_W-1:0]             out_dest_rows,
  output logic [rse2d_pkg::DEST_W-1:0]             out_dest_cols,
  output logic [rse2d_pkg::DIM_W-1:0]              out_paste_row_offset,
  output logic [rse2d_pkg::DIM_W-1:0]              out_paste_col_offset,
  input  wire logic                                cfg_we,
  input  wire logic [rse2d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rse2d_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rse2d_pkg::*;

  logic [DIM_W-1:0]        rows_r, cols_r, rows_eff, cols_eff;
  logic signed [PIX_W-1:0] thr_r;
  queue_ctl_t              q_ctl;
  summary_t                q_in, q_out;
  logic                    q_not_empty, q_pop;
  logic [QCNT_W-1:0]       q_count;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  assign rows_eff = clamp_dim(rows_r);
  assign cols_eff = clamp_dim(cols_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(1);
      cols_r <= DIM_W'(1);
      thr_r  <= PIX_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS:      rows_r <= cfg_data[DIM_W-1:0];
        CFG_COLS:      cols_r <= cfg_data[DIM_W-1:0];
        CFG_THRESHOLD: thr_r  <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  rse2d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .pixel_value (in_pixel_value),
    .last_pixel  (in_last_pixel),
    .rows_eff    (rows_eff),
    .cols_eff    (cols_eff),
    .threshold   (thr_r),
    .q_count     (q_count),
    .q_ctl       (q_ctl),
    .q_data      (q_in)
  );

  rse2d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_ctl.push),
    .push_data (q_in),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out),
    .count     (q_count)
  );

  rse2d_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_not_empty),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .empty_error      (out_empty_error),
    .crop_row_offset  (out_crop_row_offset),
    .crop_col_offset  (out_crop_col_offset),
    .crop_rows        (out_crop_rows),
    .crop_cols        (out_crop_cols),
    .dest_rows        (out_dest_rows),
    .dest_cols        (out_dest_cols),
    .paste_row_offset (out_paste_row_offset),
    .paste_col_offset (out_paste_col_offset)
  );

endmodule
`default_nettype wire
